// File: sv/mbcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcd_pkg: shared types and helpers for the meter BCD format codec
// Payload structs, action codes, double-dabble step and decimal weight tables.
// ----------------------------------------------------------------------------
package mbcd_pkg;

  // action codes
  localparam logic [1:0] ActEnc02 = 2'd0;
  localparam logic [1:0] ActDec02 = 2'd1;
  localparam logic [1:0] ActEnc03 = 2'd2;
  localparam logic [1:0] ActDec03 = 2'd3;

  // encoder converts magnitudes below 10^10, which fit in 34 bits
  localparam int BinW        = 34;
  localparam int DigitN      = 10;
  localparam int BcdW        = 4 * DigitN;
  localparam int DabbleSteps = 7;
  localparam int StageN      = (BinW + DabbleSteps - 1) / DabbleSteps;

  localparam logic [63:0] SatLimit   = 64'd10000000000;
  localparam logic [27:0] Nines7     = 28'h9999999;
  localparam logic [11:0] Nines3     = 12'h999;
  localparam logic [31:0] Sign03     = 32'h10000000;
  localparam logic [31:0] Scale03    = 32'h40000000;
  localparam logic [31:0] DigitMask3 = 32'h0fffffff;

  // weight of each BCD nibble on decode
  localparam logic [24:0] DigitWeight [7] = '{
    25'd1, 25'd10, 25'd100, 25'd1000, 25'd10000, 25'd100000, 25'd1000000
  };

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] operand;
  } cmd_t;

  typedef struct packed {
    logic signed [34:0] result_value;
    logic [31:0]        result_word;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        action;
    logic              neg;
    logic              sat;
    logic [BinW-1:0]   bin;
    logic [BcdW-1:0]   bcd;
  } dab_t;

  // one double-dabble step: correct every digit, then shift in the next bit
  function automatic logic [BcdW+BinW-1:0] dab_step(input logic [BcdW+BinW-1:0] s);
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
    logic [3:0]      nib;
    int              i;
    bcd = s[BcdW+BinW-1:BinW];
    bin = s[BinW-1:0];
    for (i = 0; i < DigitN; i++) begin
      nib = bcd[4*i +: 4];
      if (nib >= 4'd5) begin
        nib = nib + 4'd3;
      end
      bcd[4*i +: 4] = nib;
    end
    return {bcd, bin} << 1;
  endfunction

  // 10^(7-e) for the format 02 exponent
  function automatic logic [23:0] pow10_mult(input logic [2:0] e);
    logic [23:0] m;
    case (e)
      3'd0:    m = 24'd10000000;
      3'd1:    m = 24'd1000000;
      3'd2:    m = 24'd100000;
      3'd3:    m = 24'd10000;
      3'd4:    m = 24'd1000;
      3'd5:    m = 24'd100;
      3'd6:    m = 24'd10;
      default: m = 24'd1;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: sv/mbcd_dabble_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcd_dabble_stage: one registered slice of the binary-to-BCD pipeline
// Runs a fixed number of double-dabble steps and registers the result.
// ----------------------------------------------------------------------------
module mbcd_dabble_stage #(
  parameter int Steps = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mbcd_pkg::dab_t din,
  output mbcd_pkg::dab_t     dout
);
  import mbcd_pkg::*;

  dab_t dout_next;

  always_comb begin
    logic [BcdW+BinW-1:0] s;
    int                   i;
    s = {din.bcd, din.bin};
    for (i = 0; i < Steps; i++) begin
      s = dab_step(s);
    end
    dout_next     = din;
    dout_next.bcd = s[BcdW+BinW-1:BinW];
    dout_next.bin = s[BinW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/mbcd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcd_decode: format 02 / 03 word decoder
// Weights the nibbles, scales by the exponent or the x1000 bit, applies the
// sign, then delays the value to line up with the encoder pipeline.
// ----------------------------------------------------------------------------
module mbcd_decode (
  input  wire logic               clk,
  input  wire logic               fmt03,
  input  wire logic [31:0]        word,
  output logic signed [34:0]      value
);
  import mbcd_pkg::*;

  localparam int AlignDepth = 3;

  logic [24:0]        dsum;
  logic [23:0]        dmul;
  logic               dneg;
  logic [33:0]        prod;
  logic               prod_neg;
  logic [34:0]        sval;
  logic [34:0]        dly [AlignDepth];
  logic [24:0]        dsum_next;
  logic [23:0]        dmul_next;
  logic               dneg_next;
  logic [48:0]        prod_full;

  always_comb begin
    int i;
    dsum_next = '0;
    for (i = 0; i < 7; i++) begin
      if (fmt03 || (i < 3)) begin
        dsum_next = dsum_next + 25'(word[4*i +: 4]) * DigitWeight[i];
      end
    end
    if (fmt03) begin
      dmul_next = word[30] ? 24'd1000 : 24'd1;
      dneg_next = word[28];
    end else begin
      dmul_next = pow10_mult(word[15:13]);
      dneg_next = word[12];
    end
  end

  assign prod_full = dsum * dmul;

  always_ff @(posedge clk) begin
    dsum     <= dsum_next;
    dmul     <= dmul_next;
    dneg     <= dneg_next;
    // product stays below 2^34 for any nibble pattern
    prod     <= prod_full[33:0];
    prod_neg <= dneg;
    sval     <= prod_neg ? (35'd0 - {1'b0, prod}) : {1'b0, prod};
    dly[0]   <= sval;
    for (int k = 1; k < AlignDepth; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  assign value = dly[AlignDepth-1];

endmodule
`default_nettype wire

// File: sv/mbcd_format.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcd_format: result word assembly
// Picks the leading digits and exponent or scale from the BCD digits, or
// passes the decoded value, by action.
// ----------------------------------------------------------------------------
module mbcd_format (
  input  wire mbcd_pkg::dab_t     stage,
  input  wire logic signed [34:0] dec_value,
  output mbcd_pkg::res_t          res
);
  import mbcd_pkg::*;

  always_comb begin
    logic [3:0]  p;
    logic [3:0]  e;
    logic [11:0] dig3;
    logic [27:0] dig7;
    logic        big;
    int          k;

    // leading digit position, at least 2 so three digits remain
    p = 4'd2;
    for (k = 3; k < DigitN; k++) begin
      if (stage.bcd[4*k +: 4] != 4'd0) begin
        p = 4'(k);
      end
    end
    dig3 = stage.bcd[11:0];
    for (k = 2; k < DigitN; k++) begin
      if (p == 4'(k)) begin
        dig3 = stage.bcd[4*k-8 +: 12];
      end
    end
    e = 4'd9 - p;
    // saturated magnitudes are at least 10^10: exponent field 0 (largest scale), all nines
    if (stage.sat) begin
      dig3 = Nines3;
      e    = 4'd0;
    end

    big  = stage.sat || (stage.bcd[BcdW-1:28] != '0);
    dig7 = stage.sat ? Nines7 : (big ? stage.bcd[39:12] : stage.bcd[27:0]);

    res = '0;
    case (stage.action)
      ActEnc02: begin
        res.result_word = {16'd0, e[2:0], stage.neg, dig3};
        res.overflow    = stage.sat;
      end
      ActEnc03: begin
        res.result_word = ({4'd0, dig7} & DigitMask3)
                        | (stage.neg ? Sign03 : 32'd0)
                        | (big ? Scale03 : 32'd0);
        res.overflow    = stage.sat;
      end
      ActDec02, ActDec03: begin
        res.result_value = dec_value;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/meter_bcd_format_02_03_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meter_bcd_format_02_03_codec: signed binary <-> meter BCD formats 02 and 03
// Encodes to or decodes from the 16-bit format 02 and 32-bit format 03 words.
// ----------------------------------------------------------------------------
// The block takes one command every clock cycle: busy is always low, and each
// command transferred on start produces exactly one result, strobed on done
// for a single cycle, in command order. The receiver cannot stall the block and
// must take the result in that cycle. The latency is set by the encoder's
// binary-to-BCD conversion, 34 double-dabble steps spread over five pipeline
// stages, with one input register, one magnitude stage and one result register
// around it; the decoder runs alongside and is delayed to the same latency.
module meter_bcd_format_02_03_codec (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire mbcd_pkg::cmd_t cmd,
  output logic                done,
  output mbcd_pkg::res_t      result
);
  import mbcd_pkg::*;

  logic        r0_valid;
  cmd_t        r0_cmd;
  dab_t        chain [StageN+1];
  logic [63:0] mag;
  logic        neg;
  logic signed [34:0] dec_value;
  res_t        result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    r0_cmd <= cmd;
    if (rst) begin
      r0_valid <= 1'b0;
    end else begin
      r0_valid <= start && !busy;
    end
  end

  // magnitude without wrap: the most negative operand gives 2^63
  assign neg = r0_cmd.operand[63];
  assign mag = neg ? (64'd0 - r0_cmd.operand) : r0_cmd.operand;

  always_ff @(posedge clk) begin
    chain[0].action <= r0_cmd.action;
    chain[0].neg    <= neg;
    chain[0].sat    <= (mag >= SatLimit);
    chain[0].bin    <= mag[BinW-1:0];
    chain[0].bcd    <= '0;
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= r0_valid;
    end
  end

  for (genvar g = 0; g < StageN; g++) begin : g_dabble
    localparam int Left  = BinW - g * DabbleSteps;
    localparam int Steps = (Left < DabbleSteps) ? Left : DabbleSteps;
    mbcd_dabble_stage #(
      .Steps(Steps)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  mbcd_decode u_decode (
    .clk  (clk),
    .fmt03(r0_cmd.action[1]),
    .word (r0_cmd.operand[31:0]),
    .value(dec_value)
  );

  mbcd_format u_format (
    .stage    (chain[StageN]),
    .dec_value(dec_value),
    .res      (result_next)
  );

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[StageN].valid;
    end
  end

`ifndef SYNTHESIS
  a_dec_no_word: assert property (@(posedge clk) disable iff (rst)
    (chain[StageN].valid && chain[StageN].action[0])
      |=> (result.result_word == 32'd0 && !result.overflow))
    else $error("decode result carries an encoded word or overflow");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (chain[StageN].valid && !chain[StageN].action[0] && chain[StageN].sat)
      |=> (done && result.overflow))
    else $error("saturated encode lost its overflow flag");

  a_ovf_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.result_value == 35'sd0))
    else $error("overflowed encode carries a decoded value");

  a_enc02_bcd: assert property (@(posedge clk) disable iff (rst)
    (chain[StageN].valid && chain[StageN].action == ActEnc02)
      |=> (result.result_word[3:0] <= 4'd9 && result.result_word[7:4] <= 4'd9
           && result.result_word[11:8] <= 4'd9 && result.result_word[31:16] == 16'd0))
    else $error("format 02 encode produced a non-decimal digit");
`endif

endmodule
`default_nettype wire

// File: tb/meter_bcd_format_02_03_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_bcd_format_02_03_codec_test: self-checking bench for the meter codec
// Drives encode and decode commands for BCD formats 02 and 03, predicts each
// result in the bench and checks every strobed result in order.
// ----------------------------------------------------------------------------
module meter_bcd_format_02_03_codec_test;
  import mbcd_pkg::*;

  localparam int RandomCmds  = 1530;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd   = '0;
  logic done;
  res_t result;

  cmd_t commands_queued [$];
  res_t conversions_due [$];
  res_t want;
  int   mismatches = 0;
  int   cycles     = 0;
  int   gap_left   = 0;
  int   burst_left = 0;
  int   gap_pick;

  meter_bcd_format_02_03_codec DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] ten_pow(input int n);
    logic [63:0] p;
    int          i;
    p = 64'd1;
    for (i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // pack the low n decimal digits of v as BCD nibbles
  function automatic logic [31:0] digits_of(input logic [63:0] v, input int n);
    logic [31:0] r;
    int          i;
    r = '0;
    for (i = 0; i < n; i++) begin
      r[4*i +: 4] = 4'(v % 64'd10);
      v = v / 64'd10;
    end
    return r;
  endfunction

  // weight each nibble by its decimal place, valid digit or not
  function automatic logic [63:0] weigh_nibbles(input logic [31:0] w, input int n);
    logic [63:0] s;
    int          i;
    s = '0;
    for (i = 0; i < n; i++) begin
      s = s + 64'(w[4*i +: 4]) * ten_pow(i);
    end
    return s;
  endfunction

  function automatic res_t convert_cmd(input cmd_t c);
    res_t        r;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] v;
    logic        neg;
    logic        found;
    logic [2:0]  e;
    logic [31:0] w;
    int          k;
    r     = '0;
    w     = '0;
    neg   = c.operand[63];
    mag   = c.operand;
    found = 1'b0;
    if (neg) begin
      mag = ~mag + 64'd1;
    end
    case (c.action)
      ActEnc02: begin
        e = 3'd7;
        for (k = 9; k >= 3; k--) begin
          if (!found && mag >= ten_pow(k)) begin
            e     = 3'(9 - k);
            found = 1'b1;
          end
        end
        q = mag / ten_pow(7 - int'(e));
        if (q > 64'd999) begin
          w[11:0]    = 12'h999;
          r.overflow = 1'b1;
        end else begin
          w[11:0] = 12'(digits_of(q, 3));
        end
        w[12]         = neg;
        w[15:13]      = e;
        r.result_word = w;
      end
      ActEnc03: begin
        if (mag > 64'd9999999) begin
          mag   = mag / 64'd1000;
          w[30] = 1'b1;
        end
        if (mag > 64'd9999999) begin
          w[27:0]    = 28'h9999999;
          r.overflow = 1'b1;
        end else begin
          w[27:0] = 28'(digits_of(mag, 7));
        end
        w[28]         = neg;
        r.result_word = w;
      end
      ActDec02: begin
        v = weigh_nibbles({20'd0, c.operand[11:0]}, 3)
            * ten_pow(7 - int'(c.operand[15:13]));
        if (c.operand[12]) begin
          v = 64'd0 - v;
        end
        r.result_value = v[34:0];
      end
      ActDec03: begin
        v = weigh_nibbles({4'd0, c.operand[27:0]}, 7);
        if (c.operand[30]) begin
          v = v * 64'd1000;
        end
        if (c.operand[28]) begin
          v = 64'd0 - v;
        end
        r.result_value = v[34:0];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(input logic [1:0] a, input logic [63:0] v);
    cmd_t c;
    c.action  = a;
    c.operand = v;
    commands_queued.push_back(c);
  endfunction

  // driver: hold a command until it transfers, then idle or advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        conversions_due.push_back(convert_cmd(cmd));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left = gap_left - 1;
        end else if (commands_queued.size() > 0) begin
          start <= 1'b1;
          cmd   <= commands_queued.pop_front();
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
            gap_left   = 0;
          end else begin
            gap_pick = $urandom_range(0, 99);
            if (gap_pick < 3) begin
              burst_left = $urandom_range(20, 80);
            end
            if (gap_pick < 55) begin
              gap_left = 0;
            end else if (gap_pick < 90) begin
              gap_left = $urandom_range(1, 3);
            end else begin
              gap_left = $urandom_range(4, 40);
            end
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (conversions_due.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual %h", $time, result);
        mismatches++;
      end else begin
        want = conversions_due.pop_front();
        if (result.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, result.result_value);
          mismatches++;
        end
        if (result.result_word !== want.result_word) begin
          $display("%0t: result_word expected %h actual %h", $time,
                   want.result_word, result.result_word);
          mismatches++;
        end
        if (result.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, result.overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("meter_bcd_format_02_03_codec_test: errors");
      $finish;
    end
  end

  initial begin
    logic [1:0]  act;
    logic [63:0] raw;
    int          pick;
    int          n;
    int          i;
    int          k;

    // exponent and scale boundaries, saturation, most negative operand
    queue_cmd(ActEnc02, 64'd0);
    queue_cmd(ActEnc02, 64'd999);
    queue_cmd(ActEnc02, 64'd1000);
    queue_cmd(ActEnc02, -64'sd123456);
    queue_cmd(ActEnc02, 64'd999999999);
    queue_cmd(ActEnc02, 64'd1000000000);
    queue_cmd(ActEnc02, 64'd9999999999);
    queue_cmd(ActEnc02, 64'd10000000000);
    queue_cmd(ActEnc02, 64'h8000000000000000);
    queue_cmd(ActEnc02, 64'h7fffffffffffffff);
    queue_cmd(ActEnc03, 64'd9999999);
    queue_cmd(ActEnc03, 64'd10000000);
    queue_cmd(ActEnc03, -64'sd9999999999);
    queue_cmd(ActEnc03, 64'd10000000000);
    queue_cmd(ActEnc03, 64'h8000000000000000);
    queue_cmd(ActEnc03, 64'hffffffffffffffff);
    // invalid nibbles, negative zero, junk in unused bits
    queue_cmd(ActDec02, 64'h0999);
    queue_cmd(ActDec02, 64'hffff);
    queue_cmd(ActDec02, 64'h1000);
    queue_cmd(ActDec02, 64'hffffffffffff2345);
    queue_cmd(ActDec03, 64'h59999999);
    queue_cmd(ActDec03, 64'hffffffff);
    queue_cmd(ActDec03, 64'h10000000);
    queue_cmd(ActDec03, 64'hffffffffafffffff);

    for (i = 0; i < RandomCmds; i++) begin
      act  = 2'($urandom_range(0, 3));
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (act == ActEnc02 || act == ActEnc03) begin
        if (pick != 0) begin
          // spread magnitudes over decades, some right at a power of ten
          n   = $urandom_range(0, 19);
          raw = raw % ten_pow(n);
          if (pick < 3 && n > 0) begin
            raw = ten_pow(n) - 64'd2 + 64'($urandom_range(0, 3));
          end
          if ($urandom_range(0, 1) == 1) begin
            raw = ~raw + 64'd1;
          end
        end
      end else if (pick != 0) begin
        for (k = 0; k < 7; k++) begin
          raw[4*k +: 4] = 4'($urandom_range(0, 9));
        end
      end
      queue_cmd(act, raw);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (commands_queued.size() != 0 || start) @(posedge clk);
    while (conversions_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("meter_bcd_format_02_03_codec_test: clean");
    end else begin
      $display("meter_bcd_format_02_03_codec_test: errors");
    end
    $finish;
  end

endmodule
